// File: hdl/ber_tlv_header_parser_core_assert.svh
// assertion macros shared by the rtl files
`ifndef BER_TLV_HEADER_PARSER_CORE_ASSERT_SVH
`define BER_TLV_HEADER_PARSER_CORE_ASSERT_SVH

// same-cycle implication, checked on clk, off during reset
`define BTLV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define BTLV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/btlv_pkg.sv
`default_nettype none

package btlv_pkg;

  localparam int POSITION_BITS_DEF    = 16;
  localparam int MAX_LENGTH_BYTES_DEF = 3;

  localparam int REGION_W = 16;
  localparam int FIELD_W  = 16;
  localparam int BYTE_W   = 8;

  localparam logic [BYTE_W-1:0] TAG_MULTI_MASK = 8'h1F;
  localparam logic [BYTE_W-1:0] LEN_LONG_FLAG  = 8'h80;
  localparam logic [BYTE_W-1:0] LEN_COUNT_MASK = 8'h7F;

  typedef enum logic [2:0] {
    PH_TAG_FIRST,
    PH_TAG_MORE,
    PH_LEN_FIRST,
    PH_LEN_LONG,
    PH_VALUE,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TAG_INCOMPLETE,
    ST_LEN_MISSING,
    ST_LEN_FORM,
    ST_LEN_EXCEEDS,
    ST_PAST_END
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [FIELD_W-1:0]  header_offset;
    logic [FIELD_W-1:0]  tag_len;
    logic [BYTE_W-1:0]   first_tag_byte;
    logic [FIELD_W-1:0]  value_offset;
    logic [FIELD_W-1:0]  value_length;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/btlv_out_buf.sv
`default_nettype none

module btlv_out_buf
  import btlv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;
  logic    pop;

  assign pop       = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  `include "ber_tlv_header_parser_core_assert.svh"

  `BTLV_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid holds a result with empty output")
  `BTLV_ASSERT_NOW(a_no_push_when_full, push, !skid_valid_r, "result pushed into a full buffer")
  `BTLV_ASSERT_NEXT(a_skid_drains, skid_valid_r && pop, out_valid_r && !skid_valid_r, "skid did not move to output")

endmodule

`default_nettype wire

// File: hdl/ber_tlv_header_parser_core.sv
// channel  | valid      | stall      | payload
// ---------+------------+------------+--------------------------------------------------
// in       | in_valid   | in_stall   | in_data_byte, in_start_of_buffer
// out      | out_valid  | out_stall  | out_status, out_header_offset, out_tag_len,
//          |            |            | out_first_tag_byte, out_value_offset, out_value_length
// cfg      | cfg_wr_en  | -          | cfg_wr_data (region length)
//
// one byte per cycle unless in_stall is high; each transfer updates parser state when taken
// results of bytes that complete a header or fault are registered before they reach out
// output register plus one skid entry; in_stall rises only when both hold a result
// synchronous active-low reset clears parser state, region length and both result slots
// after a fault no result comes until a byte with in_start_of_buffer set

`default_nettype none

module ber_tlv_header_parser_core
  import btlv_pkg::*;
#(
  parameter int POSITION_BITS    = POSITION_BITS_DEF,
  parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                cfg_wr_en,
  input  wire logic [REGION_W-1:0] cfg_wr_data,

  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [BYTE_W-1:0]   in_data_byte,
  input  wire logic                in_start_of_buffer,

  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               out_status,
  output logic [FIELD_W-1:0]       out_header_offset,
  output logic [FIELD_W-1:0]       out_tag_len,
  output logic [BYTE_W-1:0]        out_first_tag_byte,
  output logic [FIELD_W-1:0]       out_value_offset,
  output logic [FIELD_W-1:0]       out_value_length
);

  localparam int PB  = POSITION_BITS;
  localparam int CW  = (PB > REGION_W) ? PB : REGION_W;
  localparam int AW  = 8 * MAX_LENGTH_BYTES;
  localparam int WW  = (CW > AW) ? CW : AW;
  localparam int LBW = $clog2(MAX_LENGTH_BYTES + 1);

  localparam logic [CW-1:0]      POS_MAX = CW'((64'd1 << PB) - 64'd1);
  localparam logic [CW-1:0]      CW_ONE  = CW'(1);
  localparam logic [PB-1:0]      PB_ONE  = PB'(1);
  localparam logic [LBW-1:0]     LBL_ONE = LBW'(1);
  localparam logic [6:0]         MAX_CNT = 7'(MAX_LENGTH_BYTES);
  localparam logic [FIELD_W-1:0] TAG_ONE = FIELD_W'(1);

  // state
  logic [REGION_W-1:0] region_r;
  phase_t              phase_r, phase_nxt;
  logic [PB-1:0]       pos_r, pos_nxt;
  logic [PB-1:0]       item_start_r, item_start_nxt;
  logic [FIELD_W-1:0]  tag_count_r, tag_count_nxt;
  logic [BYTE_W-1:0]   tag_head_r, tag_head_nxt;
  logic [LBW-1:0]      lbl_r, lbl_nxt;
  logic [AW-1:0]       acc_r, acc_nxt;
  logic [PB-1:0]       vbl_r, vbl_nxt;

  logic                accept;
  logic                start;
  logic [BYTE_W-1:0]   b;

  // state as seen by this byte, after a restart
  phase_t              ph_eff;
  logic [PB-1:0]       pos_eff;
  logic [PB-1:0]       item_start_eff;
  logic [FIELD_W-1:0]  tag_count_eff;
  logic [BYTE_W-1:0]   tag_head_eff;
  logic [LBW-1:0]      lbl_eff;
  logic [AW-1:0]       acc_eff;
  logic [PB-1:0]       vbl_eff;

  logic [CW-1:0]       p_ext;
  logic [CW-1:0]       region_ext;
  logic [CW-1:0]       end_ext;
  logic [CW-1:0]       rem;
  logic [WW-1:0]       rem_w;
  logic                past_end;
  logic                rem_zero;
  logic [PB-1:0]       pos_inc;
  logic [CW-1:0]       voff_ext;

  logic                tag_first;
  logic                tag_multi;
  logic                tag_cont;
  logic                len_long;
  logic [6:0]          cnt;
  logic                cnt_bad;
  logic [PB-1:0]       item_start_cur;
  logic [CW-1:0]       item_start_ext;
  logic [FIELD_W-1:0]  tag_count_cur;
  logic [BYTE_W-1:0]   tag_head_cur;
  logic [AW-1:0]       acc_cur;
  logic [WW-1:0]       acc_w;
  logic                acc_over;
  logic [LBW-1:0]      lbl_dec;
  logic [PB-1:0]       vbl_dec;

  logic                push;
  result_t             res;
  result_t             out_res;

  assign accept = in_valid && !in_stall;
  assign start  = in_start_of_buffer;
  assign b      = in_data_byte;

  assign ph_eff         = start ? PH_TAG_FIRST : phase_r;
  assign pos_eff        = start ? '0 : pos_r;
  assign item_start_eff = start ? '0 : item_start_r;
  assign tag_count_eff  = start ? '0 : tag_count_r;
  assign tag_head_eff   = start ? '0 : tag_head_r;
  assign lbl_eff        = start ? '0 : lbl_r;
  assign acc_eff        = start ? '0 : acc_r;
  assign vbl_eff        = start ? '0 : vbl_r;

  // position checks against the region end
  assign p_ext      = CW'(pos_eff);
  assign region_ext = CW'(region_r);
  assign end_ext    = (region_ext < POS_MAX) ? region_ext : POS_MAX;
  assign past_end   = p_ext >= end_ext;
  assign rem        = end_ext - p_ext - CW_ONE;
  assign rem_w      = WW'(rem);
  assign rem_zero   = (rem == '0);
  assign pos_inc    = pos_eff + PB_ONE;
  assign voff_ext   = CW'(pos_inc);

  // per-byte decode
  assign tag_first = (ph_eff == PH_TAG_FIRST);
  assign tag_multi = ((b & TAG_MULTI_MASK) == TAG_MULTI_MASK);
  assign tag_cont  = ((b & LEN_LONG_FLAG) != '0);
  assign len_long  = ((b & LEN_LONG_FLAG) != '0);
  assign cnt       = 7'(b & LEN_COUNT_MASK);
  assign cnt_bad   = (cnt == '0) || (cnt > MAX_CNT) || (WW'(cnt) > rem_w);

  assign item_start_cur = tag_first ? pos_eff : item_start_eff;
  assign item_start_ext = CW'(item_start_cur);
  assign tag_head_cur   = tag_first ? b : tag_head_eff;
  assign tag_count_cur  = tag_first ? TAG_ONE :
                          ((ph_eff == PH_TAG_MORE) ? tag_count_eff + TAG_ONE : tag_count_eff);

  assign acc_cur  = (ph_eff == PH_LEN_LONG) ? AW'({acc_eff, b}) : AW'(b);
  assign acc_w    = WW'(acc_cur);
  assign acc_over = acc_w > rem_w;

  assign lbl_dec = (lbl_eff != '0) ? lbl_eff - LBL_ONE : lbl_eff;
  assign vbl_dec = (vbl_eff != '0) ? vbl_eff - PB_ONE : vbl_eff;

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    item_start_nxt = item_start_r;
    tag_count_nxt  = tag_count_r;
    tag_head_nxt   = tag_head_r;
    lbl_nxt        = lbl_r;
    acc_nxt        = acc_r;
    vbl_nxt        = vbl_r;
    if (accept) begin
      phase_nxt      = ph_eff;
      pos_nxt        = pos_eff;
      item_start_nxt = item_start_eff;
      tag_count_nxt  = tag_count_eff;
      tag_head_nxt   = tag_head_eff;
      lbl_nxt        = lbl_eff;
      acc_nxt        = acc_eff;
      vbl_nxt        = vbl_eff;
      if (ph_eff != PH_ERROR) begin
        if (past_end) begin
          phase_nxt = PH_ERROR;
        end else begin
          pos_nxt = pos_inc;
          unique case (ph_eff)
            PH_TAG_FIRST: begin
              item_start_nxt = item_start_cur;
              tag_head_nxt   = tag_head_cur;
              tag_count_nxt  = tag_count_cur;
              if (rem_zero) begin
                phase_nxt = PH_ERROR;
              end else begin
                phase_nxt = tag_multi ? PH_TAG_MORE : PH_LEN_FIRST;
              end
            end
            PH_TAG_MORE: begin
              tag_count_nxt = tag_count_cur;
              if (rem_zero) begin
                phase_nxt = PH_ERROR;
              end else begin
                phase_nxt = tag_cont ? PH_TAG_MORE : PH_LEN_FIRST;
              end
            end
            PH_LEN_FIRST: begin
              if (!len_long) begin
                acc_nxt = acc_cur;
                if (acc_over) begin
                  phase_nxt = PH_ERROR;
                end else begin
                  phase_nxt = (acc_cur == '0) ? PH_TAG_FIRST : PH_VALUE;
                  vbl_nxt   = PB'(acc_cur);
                end
              end else if (cnt_bad) begin
                phase_nxt = PH_ERROR;
              end else begin
                lbl_nxt   = LBW'(cnt);
                acc_nxt   = '0;
                phase_nxt = PH_LEN_LONG;
              end
            end
            PH_LEN_LONG: begin
              acc_nxt = acc_cur;
              lbl_nxt = lbl_dec;
              if (lbl_dec == '0) begin
                if (acc_over) begin
                  phase_nxt = PH_ERROR;
                end else begin
                  phase_nxt = (acc_cur == '0) ? PH_TAG_FIRST : PH_VALUE;
                  vbl_nxt   = PB'(acc_cur);
                end
              end else if (rem_zero) begin
                phase_nxt = PH_ERROR;
              end
            end
            PH_VALUE: begin
              vbl_nxt = vbl_dec;
              if (vbl_dec == '0) begin
                phase_nxt = PH_TAG_FIRST;
              end
            end
            default: begin
              phase_nxt = PH_ERROR;
            end
          endcase
        end
      end
    end
  end

  // result
  always_comb begin
    push               = 1'b0;
    res.status         = ST_OK;
    res.header_offset  = item_start_ext[FIELD_W-1:0];
    res.tag_len        = tag_count_cur;
    res.first_tag_byte = tag_head_cur;
    res.value_offset   = '0;
    res.value_length   = '0;
    if (accept && ph_eff != PH_ERROR) begin
      if (past_end) begin
        push               = 1'b1;
        res.status         = ST_PAST_END;
        res.header_offset  = p_ext[FIELD_W-1:0];
        res.tag_len        = '0;
        res.first_tag_byte = '0;
      end else begin
        unique case (ph_eff)
          PH_TAG_FIRST: begin
            if (rem_zero) begin
              push       = 1'b1;
              res.status = tag_multi ? ST_TAG_INCOMPLETE : ST_LEN_MISSING;
            end
          end
          PH_TAG_MORE: begin
            if (rem_zero) begin
              push       = 1'b1;
              res.status = tag_cont ? ST_TAG_INCOMPLETE : ST_LEN_MISSING;
            end
          end
          PH_LEN_FIRST, PH_LEN_LONG: begin
            if ((ph_eff == PH_LEN_FIRST && !len_long) ||
                (ph_eff == PH_LEN_LONG && lbl_dec == '0)) begin
              push = 1'b1;
              if (acc_over) begin
                res.status = ST_LEN_EXCEEDS;
              end else begin
                res.value_offset = voff_ext[FIELD_W-1:0];
                res.value_length = acc_w[FIELD_W-1:0];
              end
            end else if ((ph_eff == PH_LEN_FIRST && cnt_bad) ||
                         (ph_eff == PH_LEN_LONG && rem_zero)) begin
              push       = 1'b1;
              res.status = ST_LEN_FORM;
            end
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r     <= '0;
      phase_r      <= PH_TAG_FIRST;
      pos_r        <= '0;
      item_start_r <= '0;
      tag_count_r  <= '0;
      tag_head_r   <= '0;
      lbl_r        <= '0;
      acc_r        <= '0;
      vbl_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        region_r <= cfg_wr_data;
      end
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      item_start_r <= item_start_nxt;
      tag_count_r  <= tag_count_nxt;
      tag_head_r   <= tag_head_nxt;
      lbl_r        <= lbl_nxt;
      acc_r        <= acc_nxt;
      vbl_r        <= vbl_nxt;
    end
  end

  btlv_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_status         = out_res.status;
  assign out_header_offset  = out_res.header_offset;
  assign out_tag_len        = out_res.tag_len;
  assign out_first_tag_byte = out_res.first_tag_byte;
  assign out_value_offset   = out_res.value_offset;
  assign out_value_length   = out_res.value_length;

  `include "ber_tlv_header_parser_core_assert.svh"

  `BTLV_ASSERT_NOW(a_silent_in_error, accept && phase_r == PH_ERROR && !start, !push, "result produced while in error")
  `BTLV_ASSERT_NEXT(a_fault_enters_error, push && res.status != ST_OK, phase_r == PH_ERROR, "fault result without error state")
  `BTLV_ASSERT_NOW(a_ok_keeps_running, push && res.status == ST_OK, phase_nxt != PH_ERROR, "ok result while entering error")
  `BTLV_ASSERT_NOW(a_value_has_bytes, phase_r == PH_VALUE, vbl_r != '0, "value phase with no bytes left")

endmodule

`default_nettype wire

// File: tb/sv/ber_tlv_header_parser_core_checker.sv
`default_nettype none

module ber_tlv_header_parser_core_checker
  import btlv_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [REGION_W-1:0] cfg_wr_data,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire logic [BYTE_W-1:0]   in_data_byte,
  input  wire logic                in_start_of_buffer,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire logic [2:0]          out_status,
  input  wire logic [FIELD_W-1:0]  out_header_offset,
  input  wire logic [FIELD_W-1:0]  out_tag_len,
  input  wire logic [BYTE_W-1:0]   out_first_tag_byte,
  input  wire logic [FIELD_W-1:0]  out_value_offset,
  input  wire logic [FIELD_W-1:0]  out_value_length,
  output int                       fail_count,
  output int                       expected_left
);

  localparam logic [FIELD_W-1:0] F_ONE = FIELD_W'(1);

  logic [REGION_W-1:0] region_len;
  phase_t              ph;
  logic [FIELD_W-1:0]  pos;
  logic [FIELD_W-1:0]  item_pos;
  logic [FIELD_W-1:0]  tag_cnt;
  logic [BYTE_W-1:0]   tag_first;
  logic [1:0]          len_left;
  logic [31:0]         len_acc;
  logic [FIELD_W-1:0]  value_left;
  result_t             headers_due[$];
  result_t             want;
  result_t             fresh;
  bit                  got;
  int                  n_bad = 0;

  assign fail_count = n_bad;

  function automatic void clear_parser();
    ph         = PH_TAG_FIRST;
    pos        = '0;
    item_pos   = '0;
    tag_cnt    = '0;
    tag_first  = '0;
    len_left   = '0;
    len_acc    = '0;
    value_left = '0;
  endfunction

  function automatic result_t fault(status_t st);
    result_t r;
    ph               = PH_ERROR;
    r                = '0;
    r.status         = st;
    r.header_offset  = item_pos;
    r.tag_len        = tag_cnt;
    r.first_tag_byte = tag_first;
    return r;
  endfunction

  function automatic result_t close_header(logic [FIELD_W-1:0] p, logic [31:0] rem);
    result_t r;
    if (len_acc > rem) begin
      return fault(ST_LEN_EXCEEDS);
    end
    if (len_acc == 0) begin
      ph = PH_TAG_FIRST;
    end else begin
      ph         = PH_VALUE;
      value_left = len_acc[FIELD_W-1:0];
    end
    r                = '0;
    r.status         = ST_OK;
    r.header_offset  = item_pos;
    r.tag_len        = tag_cnt;
    r.first_tag_byte = tag_first;
    r.value_offset   = p + F_ONE;
    r.value_length   = len_acc[FIELD_W-1:0];
    return r;
  endfunction

  // advances the parser by one byte, returns 1 when a result is due
  function automatic bit parse_byte(input logic [BYTE_W-1:0] b, input logic sob,
                                    output result_t r);
    logic [FIELD_W-1:0] p;
    logic [31:0]        rem;
    logic [31:0]        cnt;
    r = '0;
    if (sob) begin
      clear_parser();
    end
    if (ph == PH_ERROR) begin
      return 0;
    end
    p = pos;
    if (p >= region_len) begin
      ph              = PH_ERROR;
      r.status        = ST_PAST_END;
      r.header_offset = p;
      return 1;
    end
    rem = 32'(region_len) - 32'(p) - 32'd1;
    pos = p + F_ONE;
    case (ph)
      PH_TAG_FIRST: begin
        item_pos  = p;
        tag_first = b;
        tag_cnt   = F_ONE;
        if ((b & TAG_MULTI_MASK) == TAG_MULTI_MASK) begin
          ph = PH_TAG_MORE;
        end else begin
          ph = PH_LEN_FIRST;
        end
        if (rem == 0) begin
          r = fault(ph == PH_TAG_MORE ? ST_TAG_INCOMPLETE : ST_LEN_MISSING);
          return 1;
        end
        return 0;
      end
      PH_TAG_MORE: begin
        tag_cnt = tag_cnt + F_ONE;
        if ((b & LEN_LONG_FLAG) == 0) begin
          ph = PH_LEN_FIRST;
        end
        if (rem == 0) begin
          r = fault(ph == PH_TAG_MORE ? ST_TAG_INCOMPLETE : ST_LEN_MISSING);
          return 1;
        end
        return 0;
      end
      PH_LEN_FIRST: begin
        if ((b & LEN_LONG_FLAG) == 0) begin
          len_acc = {24'h0, b};
          r = close_header(p, rem);
          return 1;
        end
        cnt = 32'(b & LEN_COUNT_MASK);
        if (cnt == 0 || cnt > MAX_LENGTH_BYTES_DEF || cnt > rem) begin
          r = fault(ST_LEN_FORM);
          return 1;
        end
        len_left = cnt[1:0];
        len_acc  = '0;
        ph       = PH_LEN_LONG;
        return 0;
      end
      PH_LEN_LONG: begin
        len_acc = {len_acc[23:0], b};
        if (len_left > 0) begin
          len_left = len_left - 2'd1;
        end
        if (len_left == 0) begin
          r = close_header(p, rem);
          return 1;
        end
        if (rem == 0) begin
          r = fault(ST_LEN_FORM);
          return 1;
        end
        return 0;
      end
      PH_VALUE: begin
        if (value_left > 0) begin
          value_left = value_left - F_ONE;
        end
        if (value_left == 0) begin
          ph = PH_TAG_FIRST;
        end
        return 0;
      end
      default: begin
        ph = PH_ERROR;
        return 0;
      end
    endcase
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      n_bad++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      region_len = '0;
      clear_parser();
      headers_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (headers_due.size() == 0) begin
          $error("result with none expected: status %0d, header_offset %0d",
                 out_status, out_header_offset);
          n_bad++;
        end else begin
          want = headers_due.pop_front();
          check_field("status", want.status, out_status);
          check_field("header_offset", want.header_offset, out_header_offset);
          check_field("tag_len", want.tag_len, out_tag_len);
          check_field("first_tag_byte", want.first_tag_byte, out_first_tag_byte);
          check_field("value_offset", want.value_offset, out_value_offset);
          check_field("value_length", want.value_length, out_value_length);
        end
      end
      if (in_valid && !in_stall) begin
        got = parse_byte(in_data_byte, in_start_of_buffer, fresh);
        if (got) begin
          headers_due.insert(headers_due.size(), fresh);
        end
      end
      // new region length applies from the next byte
      if (cfg_wr_en) begin
        region_len = cfg_wr_data;
      end
    end
    expected_left <= headers_due.size();
  end

endmodule

`default_nettype wire

// File: tb/sv/ber_tlv_header_parser_core_tb.sv
`default_nettype none

module ber_tlv_header_parser_core_tb;
  import btlv_pkg::*;

  logic                clk                = 1'b0;
  logic                rst_n              = 1'b0;
  logic                cfg_wr_en          = 1'b0;
  logic [REGION_W-1:0] cfg_wr_data        = '0;
  logic                in_valid           = 1'b0;
  logic [BYTE_W-1:0]   in_data_byte       = '0;
  logic                in_start_of_buffer = 1'b0;
  logic                out_stall          = 1'b0;
  wire logic               in_stall;
  wire logic               out_valid;
  wire logic [2:0]         out_status;
  wire logic [FIELD_W-1:0] out_header_offset;
  wire logic [FIELD_W-1:0] out_tag_len;
  wire logic [BYTE_W-1:0]  out_first_tag_byte;
  wire logic [FIELD_W-1:0] out_value_offset;
  wire logic [FIELD_W-1:0] out_value_length;
  int                  fail_count;
  int                  expected_left;

  int                  send_pct    = 0;
  int                  recv_pct    = 0;
  bit                  hold_go     = 1'b0;
  int                  hold_cycles = 0;
  int                  quiet_cycles = 0;
  int                  sent_bytes  = 0;
  logic [BYTE_W-1:0]   buf_bytes[$];

  always #1 clk = ~clk;

  ber_tlv_header_parser_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_start_of_buffer (in_start_of_buffer),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_header_offset  (out_header_offset),
    .out_tag_len        (out_tag_len),
    .out_first_tag_byte (out_first_tag_byte),
    .out_value_offset   (out_value_offset),
    .out_value_length   (out_value_length)
  );

  ber_tlv_header_parser_core_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_start_of_buffer (in_start_of_buffer),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_header_offset  (out_header_offset),
    .out_tag_len        (out_tag_len),
    .out_first_tag_byte (out_first_tag_byte),
    .out_value_offset   (out_value_offset),
    .out_value_length   (out_value_length),
    .fail_count         (fail_count),
    .expected_left      (expected_left)
  );

  // result receiver, with one long hold-off to back up the block
  always @(posedge clk) begin
    if (hold_go && hold_cycles < 120) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= 3000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void put_byte(input logic [BYTE_W-1:0] v);
    buf_bytes.insert(buf_bytes.size(), v);
  endfunction

  task automatic feed(input logic [BYTE_W-1:0] b, input logic sob);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data_byte       <= b;
    in_start_of_buffer <= sob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    repeat (4) @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_region(input logic [REGION_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_buffer();
    foreach (buf_bytes[i]) feed(buf_bytes[i], i == 0);
  endtask

  // appends one well-formed item with random content
  task automatic add_item();
    logic [BYTE_W-1:0] t;
    int                vlen;
    int                n;
    t = 8'($urandom);
    if ($urandom_range(3) == 0) begin
      t[4:0] = 5'h1F;
      put_byte(t);
      repeat ($urandom_range(2)) put_byte(8'($urandom) | LEN_LONG_FLAG);
      put_byte(8'($urandom) & LEN_COUNT_MASK);
    end else begin
      if (t[4:0] == 5'h1F) begin
        t[0] = 1'b0;
      end
      put_byte(t);
    end
    vlen = ($urandom_range(9) == 0) ? $urandom_range(140) : $urandom_range(6);
    if (vlen < 128 && $urandom_range(2) != 0) begin
      put_byte(8'(vlen));
    end else begin
      n = $urandom_range(1, MAX_LENGTH_BYTES_DEF);
      put_byte(LEN_LONG_FLAG | 8'(n));
      for (int k = n - 1; k >= 0; k--) put_byte(8'(vlen >> (8 * k)));
    end
    repeat (vlen) put_byte(8'($urandom));
  endtask

  task automatic make_buffer(input int region);
    int target;
    buf_bytes.delete();
    if (region > 60) begin
      target = $urandom_range(1, 60);
    end else if ($urandom_range(3) == 0) begin
      target = $urandom_range(1, region + 1);
    end else if ($urandom_range(2) == 0) begin
      target = region + $urandom_range(1, 3);
    end else begin
      target = (region == 0) ? 1 : region;
    end
    while (buf_bytes.size() < target) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
      end else begin
        add_item();
      end
    end
    while (buf_bytes.size() > target) void'(buf_bytes.pop_back());
  endtask

  initial begin
    int region;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty region, then silence after the fault
    set_region(16'd0);
    feed(8'h00, 1'b1);
    feed(8'hFF, 1'b0);

    // short and multi-byte tags, value skip, byte past the end
    set_region(16'd8);
    feed(8'h00, 1'b1);
    feed(8'h00, 1'b0);
    feed(8'hFF, 1'b0);
    feed(8'h81, 1'b0);
    feed(8'h7F, 1'b0);
    feed(8'h02, 1'b0);
    feed(8'hAA, 1'b0);
    feed(8'h55, 1'b0);
    feed(8'h3C, 1'b0);

    // region ends inside the tag, then before the length
    set_region(16'd3);
    feed(8'h1F, 1'b1);
    feed(8'h80, 1'b0);
    feed(8'h80, 1'b0);
    set_region(16'd1);
    feed(8'h01, 1'b1);

    // long-form count larger than what is left
    set_region(16'd2);
    feed(8'h01, 1'b1);
    feed(8'h81, 1'b0);

    // indefinite form, count too big, long form ok, value too long
    set_region(16'd16);
    feed(8'h01, 1'b1);
    feed(8'h80, 1'b0);
    feed(8'h01, 1'b1);
    feed(8'h84, 1'b0);
    feed(8'h01, 1'b1);
    feed(8'h83, 1'b0);
    feed(8'h00, 1'b0);
    feed(8'h00, 1'b0);
    feed(8'h05, 1'b0);
    feed(8'h02, 1'b1);
    feed(8'h0F, 1'b0);
    feed(8'h01, 1'b1);
    feed(8'h83, 1'b0);
    feed(8'hFF, 1'b0);
    feed(8'hFF, 1'b0);
    feed(8'hFF, 1'b0);

    // region shrinks between bytes of one buffer
    feed(8'h05, 1'b1);
    feed(8'h03, 1'b0);
    feed(8'h11, 1'b0);
    set_region(16'd3);
    feed(8'h22, 1'b0);

    // dense results while the receiver holds off
    set_region(16'd200);
    hold_go <= 1'b1;
    for (int i = 0; i < 50; i++) begin
      feed(8'h01, i == 0);
      feed(8'h00, 1'b0);
    end

    for (int m = 0; m < 3; m++) begin
      send_pct <= (m == 0) ? 23 : (m == 1) ? 53 : 0;
      recv_pct <= (m == 0) ? 53 : (m == 1) ? 23 : 0;
      while (sent_bytes < 400 + 350 * m) begin
        case ($urandom_range(19))
          0:       region = 16'hFFFF;
          1, 2, 3: region = $urandom_range(0, 4);
          default: region = $urandom_range(5, 48);
        endcase
        set_region(16'(region));
        repeat ($urandom_range(1, 3)) begin
          make_buffer(region);
          send_buffer();
        end
      end
    end

    drain();
    if (fail_count == 0 && expected_left == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: ber_tlv_header_parser_core.f
+incdir+hdl
hdl/btlv_pkg.sv
hdl/btlv_out_buf.sv
hdl/ber_tlv_header_parser_core.sv
tb/sv/ber_tlv_header_parser_core_checker.sv
tb/sv/ber_tlv_header_parser_core_tb.sv
